[sv/triangle_box_overlap_query_core_assert.svh]
// Assertion macros for the triangle box overlap query core checker
`ifndef TRIANGLE_BOX_OVERLAP_QUERY_CORE_ASSERT_SVH
`define TRIANGLE_BOX_OVERLAP_QUERY_CORE_ASSERT_SVH

// same-cycle implication
`define TBO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBO_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tbo_pkg.sv]
// Shared constants, types and helpers for the triangle box overlap query core
`default_nettype none
package tbo_pkg;

    localparam int MAX_TRIANGLES = 1024;
    localparam int ADDR_W        = $clog2(MAX_TRIANGLES);
    localparam int CNT_W         = $clog2(MAX_TRIANGLES + 1);

    localparam int COORD_W = 20;
    localparam int SIZE_W  = 19;
    localparam int REQ_W   = 2;
    localparam int SLOT_W  = 2;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = REQ_W + SLOT_W;
    localparam int M_TDATA_W = 16;

    localparam int P_W    = COORD_W + 1;
    localparam int E_W    = P_W + 1;
    localparam int EP_W   = E_W + P_W;
    localparam int EA_W   = EP_W + 2;
    localparam int ES_W   = E_W + 1;
    localparam int EX_W   = SIZE_W + ES_W;
    localparam int NPR_W  = 2 * E_W;
    localparam int N_W    = NPR_W + 1;
    localparam int NL_W   = E_W;
    localparam int NH_W   = N_W - NL_W;
    localparam int NPP_W  = NH_W + P_W;
    localparam int NS_W   = N_W + 1;
    localparam int SL_W   = 24;
    localparam int SH_W   = NS_W - SL_W;
    localparam int NF_W   = N_W + P_W + 2;
    localparam int NX_W   = SIZE_W + NS_W;
    localparam int CMP_W  = NF_W + 1;
    localparam int BX_W   = P_W + 1;

    localparam int PIPE_DEPTH = 8;

    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    localparam logic [SLOT_W-1:0] SLOT_FIRST  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_SECOND = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_THIRD  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vertex_t;

    typedef vertex_t [2:0] tri_t;

    typedef struct packed {
        vertex_t           ctr;
        logic [SIZE_W-1:0] size;
    } cube_t;

    typedef struct packed {
        logic [2:0]        we;
        logic [ADDR_W-1:0] addr;
        vertex_t           data;
    } store_wr_t;

    typedef struct packed {
        logic busy;
        logic res_valid;
        logic res_hit;
    } pipe_stat_t;

    function automatic logic signed [COORD_W-1:0] vtx_coord(input vertex_t v, input int c);
        logic signed [COORD_W-1:0] r;
        case (c)
            0:       r = v.x;
            1:       r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

    function automatic logic [E_W-1:0] abs_e(input logic signed [E_W-1:0] v);
        return v[E_W-1] ? E_W'(-v) : E_W'(v);
    endfunction

    function automatic logic [N_W-1:0] abs_n(input logic signed [N_W-1:0] v);
        return v[N_W-1] ? N_W'(-v) : N_W'(v);
    endfunction

endpackage
`default_nettype wire

[sv/triangle_box_overlap_query_core.sv]
// Top level: request decode, store control, query scan and result register
//
//  channel | ports                         | payload (low bits first)
//  --------+-------------------------------+-----------------------------------------
//  request | s_tvalid s_tready s_tdata/user| x, y, z, box_size ; req_type, vertex_slot
//  result  | m_tvalid m_tready m_tdata     | overlap, status, triangles_held
//
//  Clear and load write their result to the output register, which holds it the next cycle.
//  A query scans the store with one read per cycle feeding the eight-stage axis
//  test pipeline, then the pipeline drains; a query on an empty store answers without a scan.
//  Synchronous active-low reset empties the store count; memory contents are kept.
//  A new request is taken only when idle and the result register is free or being read.
`default_nettype none
module triangle_box_overlap_query_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // coord_x, coord_y, coord_z, box_size, zero pad
    input  wire logic [tbo_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type, vertex_slot
    input  wire logic [tbo_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // overlap, status, triangles_held, zero pad
    output logic [tbo_pkg::M_TDATA_W-1:0]        m_tdata
);
    import tbo_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]        state_reg,     state_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [CNT_W-1:0]  idx_reg,       idx_next;
    logic              rd_vld_reg,    rd_vld_next;
    logic              hit_reg,       hit_next;
    cube_t             cube_reg,      cube_next;
    logic              out_valid_reg, out_valid_next;
    logic              overlap_reg,   overlap_next;
    logic              status_reg,    status_next;
    logic [CNT_W-1:0]  held_reg,      held_next;

    logic              accept;
    logic              out_free;
    logic [REQ_W-1:0]  req_type;
    logic [SLOT_W-1:0] vertex_slot;
    vertex_t           s_vtx;
    store_wr_t         wr;
    tri_t              rd_data;
    pipe_stat_t        pstat;

    assign req_type    = s_tuser[REQ_W-1:0];
    assign vertex_slot = s_tuser[REQ_W+SLOT_W-1:REQ_W];
    assign s_vtx.x     = s_tdata[COORD_W-1:0];
    assign s_vtx.y     = s_tdata[2*COORD_W-1:COORD_W];
    assign s_vtx.z     = s_tdata[3*COORD_W-1:2*COORD_W];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rd_vld_next    = 1'b0;
        hit_next       = hit_reg;
        cube_next      = cube_reg;
        out_valid_next = out_valid_reg && !m_tready;
        overlap_next   = overlap_reg;
        status_next    = status_reg;
        held_next      = held_reg;
        wr.we          = '0;
        wr.addr        = count_reg[ADDR_W-1:0];
        wr.data        = s_vtx;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    out_valid_next = 1'b1;
                    overlap_next   = 1'b0;
                    status_next    = 1'b0;
                    case (req_type)
                        REQ_CLEAR: begin
                            count_next = '0;
                        end
                        REQ_LOAD: begin
                            if (vertex_slot == SLOT_FIRST || vertex_slot == SLOT_SECOND
                                || vertex_slot == SLOT_THIRD) begin
                                if (count_reg >= CNT_W'(MAX_TRIANGLES)) begin
                                    status_next = 1'b1;
                                end else begin
                                    wr.we[vertex_slot] = 1'b1;
                                    if (vertex_slot == SLOT_THIRD) begin
                                        count_next = count_reg + 1'b1;
                                    end
                                end
                            end
                        end
                        REQ_QUERY: begin
                            cube_next.ctr  = s_vtx;
                            cube_next.size = s_tdata[3*COORD_W+SIZE_W-1:3*COORD_W];
                            if (count_reg != '0) begin
                                out_valid_next = 1'b0;
                                idx_next       = '0;
                                hit_next       = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                    held_next = count_next;
                end
            end
            ST_SCAN: begin
                rd_vld_next = 1'b1;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == count_reg - 1'b1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pstat.busy && !rd_vld_reg && out_free) begin
                    out_valid_next = 1'b1;
                    overlap_next   = hit_reg;
                    status_next    = 1'b0;
                    held_next      = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (pstat.res_valid && pstat.res_hit) begin
            hit_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rd_vld_reg    <= rd_vld_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cube_reg    <= cube_next;
        overlap_reg <= overlap_next;
        status_reg  <= status_next;
        held_reg    <= held_next;
    end

    tbo_vertex_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    tbo_sat_pipe u_pipe (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_vld_reg),
        .tri_in   (rd_data),
        .cube     (cube_reg),
        .stat     (pstat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - CNT_W - 2)'(0), held_reg, status_reg, overlap_reg};

endmodule
`default_nettype wire

[sv/tbo_vertex_store.sv]
// Three vertex memories with one write port and a registered shared read port
`default_nettype none
module tbo_vertex_store (
    input  wire logic                      aclk,
    input  wire tbo_pkg::store_wr_t        wr,
    input  wire logic [tbo_pkg::ADDR_W-1:0] rd_addr,
    output tbo_pkg::tri_t                  rd_data
);
    import tbo_pkg::*;

    vertex_t vert0_mem [MAX_TRIANGLES];
    vertex_t vert1_mem [MAX_TRIANGLES];
    vertex_t vert2_mem [MAX_TRIANGLES];
    tri_t    rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we[0]) begin
            vert0_mem[wr.addr] <= wr.data;
        end
        if (wr.we[1]) begin
            vert1_mem[wr.addr] <= wr.data;
        end
        if (wr.we[2]) begin
            vert2_mem[wr.addr] <= wr.data;
        end
        rd_data_reg[0] <= vert0_mem[rd_addr];
        rd_data_reg[1] <= vert1_mem[rd_addr];
        rd_data_reg[2] <= vert2_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[sv/tbo_sat_pipe.sv]
// Pipelined separating axis test of one triangle against the latched cube
`default_nettype none
module tbo_sat_pipe (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire tbo_pkg::tri_t       tri_in,
    input  wire tbo_pkg::cube_t      cube,
    output tbo_pkg::pipe_stat_t      stat
);
    import tbo_pkg::*;

    logic [PIPE_DEPTH-1:0] vld_reg;

    logic signed [P_W-1:0]   p1_reg  [3][3];
    logic signed [P_W-1:0]   p2_reg  [3][3];
    logic signed [E_W-1:0]   e2_reg  [3][3];
    logic signed [P_W-1:0]   p3_reg  [3][3];
    logic signed [NPR_W-1:0] npa3_reg [3];
    logic signed [NPR_W-1:0] npb3_reg [3];
    logic signed [EP_W-1:0]  epa3_reg [3][3][3];
    logic signed [EP_W-1:0]  epb3_reg [3][3][3];
    logic [ES_W-1:0]         es3_reg  [3][3];
    logic signed [EA_W-1:0]  ef4_reg  [3][3][3];
    logic [EX_W-1:0]         ex4_reg  [3][3];
    logic signed [N_W-1:0]   n4_reg   [3];
    logic signed [P_W-1:0]   p04_reg  [3];
    logic                    box4_reg;
    logic signed [NPP_W-1:0] nlp5_reg [3];
    logic signed [NPP_W-1:0] nhp5_reg [3];
    logic [NS_W-1:0]         ns5_reg;
    logic                    box5_reg;
    logic                    edge5_reg;
    logic signed [NF_W-1:0]  nf6_reg;
    logic [SIZE_W+SL_W-1:0]  xl6_reg;
    logic [SIZE_W+SH_W-1:0]  xh6_reg;
    logic                    flag6_reg;
    logic signed [NF_W-1:0]  nf7_reg;
    logic [NX_W-1:0]         nx7_reg;
    logic                    flag7_reg;
    logic                    hit8_reg;

    logic                    box_next;
    logic                    edge_next;
    logic                    norm_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    always_comb begin
        logic signed [BX_W-1:0] bx;
        logic signed [BX_W-1:0] f0;
        logic signed [BX_W-1:0] f1;
        logic signed [BX_W-1:0] f2;
        logic signed [EA_W-1:0] ex;
        logic signed [CMP_W-1:0] nf2;
        logic signed [CMP_W-1:0] nx;
        bx       = $signed(BX_W'(cube.size));
        box_next = 1'b1;
        for (int c = 0; c < 3; c++) begin
            f0 = BX_W'(p3_reg[0][c]) <<< 1;
            f1 = BX_W'(p3_reg[1][c]) <<< 1;
            f2 = BX_W'(p3_reg[2][c]) <<< 1;
            if (!((f0 <= bx) || (f1 <= bx) || (f2 <= bx))
                || !((f0 >= -bx) || (f1 >= -bx) || (f2 >= -bx))) begin
                box_next = 1'b0;
            end
        end
        edge_next = 1'b1;
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                ex = $signed(EA_W'(ex4_reg[i][k]));
                if (!((ef4_reg[i][k][0] <= ex) || (ef4_reg[i][k][1] <= ex)
                      || (ef4_reg[i][k][2] <= ex))
                    || !((ef4_reg[i][k][0] >= -ex) || (ef4_reg[i][k][1] >= -ex)
                      || (ef4_reg[i][k][2] >= -ex))) begin
                    edge_next = 1'b0;
                end
            end
        end
        nf2       = CMP_W'(nf7_reg) <<< 1;
        nx        = $signed(CMP_W'(nx7_reg));
        norm_next = (nf2 <= nx) && (nf2 >= -nx);
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 3; j++) begin
            for (int c = 0; c < 3; c++) begin
                p1_reg[j][c] <= P_W'(vtx_coord(tri_in[j], c)) - P_W'(vtx_coord(cube.ctr, c));
            end
        end

        for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
                p2_reg[i][c] <= p1_reg[i][c];
                e2_reg[i][c] <= E_W'(p1_reg[(i == 2) ? 0 : i + 1][c]) - E_W'(p1_reg[i][c]);
            end
        end

        for (int k = 0; k < 3; k++) begin
            int u;
            int w;
            u = (k == 2) ? 0 : k + 1;
            w = (k == 0) ? 2 : k - 1;
            npa3_reg[k] <= NPR_W'(e2_reg[0][u]) * NPR_W'(e2_reg[1][w]);
            npb3_reg[k] <= NPR_W'(e2_reg[0][w]) * NPR_W'(e2_reg[1][u]);
            for (int i = 0; i < 3; i++) begin
                es3_reg[i][k] <= ES_W'(abs_e(e2_reg[i][u])) + ES_W'(abs_e(e2_reg[i][w]));
                for (int j = 0; j < 3; j++) begin
                    epa3_reg[i][k][j] <= EP_W'(e2_reg[i][w]) * EP_W'(p2_reg[j][u]);
                    epb3_reg[i][k][j] <= EP_W'(e2_reg[i][u]) * EP_W'(p2_reg[j][w]);
                end
            end
            for (int j = 0; j < 3; j++) begin
                p3_reg[j][k] <= p2_reg[j][k];
            end
        end

        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                ex4_reg[i][k] <= EX_W'(cube.size) * EX_W'(es3_reg[i][k]);
                for (int j = 0; j < 3; j++) begin
                    ef4_reg[i][k][j] <= (EA_W'(epa3_reg[i][k][j])
                                        - EA_W'(epb3_reg[i][k][j])) <<< 1;
                end
            end
            n4_reg[i]  <= N_W'(npa3_reg[i]) - N_W'(npb3_reg[i]);
            p04_reg[i] <= p3_reg[0][i];
        end
        box4_reg <= box_next;

        for (int c = 0; c < 3; c++) begin
            nlp5_reg[c] <= NPP_W'($signed({1'b0, n4_reg[c][NL_W-1:0]})) * NPP_W'(p04_reg[c]);
            nhp5_reg[c] <= NPP_W'($signed(n4_reg[c][N_W-1:NL_W])) * NPP_W'(p04_reg[c]);
        end
        ns5_reg   <= NS_W'(abs_n(n4_reg[0])) + NS_W'(abs_n(n4_reg[1]))
                     + NS_W'(abs_n(n4_reg[2]));
        box5_reg  <= box4_reg;
        edge5_reg <= edge_next;

        nf6_reg   <= ((NF_W'(nhp5_reg[0]) <<< NL_W) + NF_W'(nlp5_reg[0]))
                     + ((NF_W'(nhp5_reg[1]) <<< NL_W) + NF_W'(nlp5_reg[1]))
                     + ((NF_W'(nhp5_reg[2]) <<< NL_W) + NF_W'(nlp5_reg[2]));
        xl6_reg   <= (SIZE_W + SL_W)'(cube.size) * (SIZE_W + SL_W)'(ns5_reg[SL_W-1:0]);
        xh6_reg   <= (SIZE_W + SH_W)'(cube.size) * (SIZE_W + SH_W)'(ns5_reg[NS_W-1:SL_W]);
        flag6_reg <= box5_reg & edge5_reg;

        nf7_reg   <= nf6_reg;
        nx7_reg   <= (NX_W'(xh6_reg) << SL_W) + NX_W'(xl6_reg);
        flag7_reg <= flag6_reg;

        hit8_reg  <= flag7_reg & norm_next;
    end

    assign stat.busy      = |vld_reg;
    assign stat.res_valid = vld_reg[PIPE_DEPTH-1];
    assign stat.res_hit   = hit8_reg;

endmodule
`default_nettype wire

[sv/tbo_checker.sv]
// Port-level checker for the triangle box overlap query core, bound to the top level
`default_nettype none
`include "triangle_box_overlap_query_core_assert.svh"
module tbo_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [tbo_pkg::M_TDATA_W-1:0]   m_tdata
);
    import tbo_pkg::*;

    `TBO_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `TBO_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, m_tvalid || !s_tready, "request taken without result or busy")
    `TBO_ASSERT_IMP(a_held_range, m_tvalid, m_tdata[CNT_W+1:2] <= CNT_W'(MAX_TRIANGLES), "triangle count beyond capacity")
    `TBO_ASSERT_IMP(a_empty_no_hit, m_tvalid && m_tdata[CNT_W+1:2] == '0, !m_tdata[0], "overlap reported on empty store")

endmodule

bind triangle_box_overlap_query_core tbo_checker u_tbo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
